// ===== src/bmo_pkg.sv =====
// ---------------------------------------------------------------------------
// bmo_pkg
// Shared constants, widths and the arctangent table of the odometry block.
// ---------------------------------------------------------------------------
package bmo_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int CSTEPS       = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int CNT_W        = 5;
  localparam int ZW           = ANGLE_BITS + 2;
  localparam int CW           = 34;

  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  localparam logic [21:0] HEAD_K   = 22'd2799883;

  // serial multiplier and divider sizes
  localparam int MA_W = 36;
  localparam int MB_W = 32;
  localparam int MP_W = MA_W + MB_W;
  localparam int DN_W = 60;
  localparam int DD_W = 48;

  // configuration register indexes
  localparam logic [1:0] REG_WHEELBASE = 2'd0;
  localparam logic [1:0] REG_RATIO     = 2'd1;
  localparam logic [1:0] REG_DEADBAND  = 2'd2;

  // arctangent of 2^-i, 2^32 per circle, rounded to ANGLE_BITS
  function automatic logic [ZW-1:0] atan_step(input logic [CNT_W-1:0] idx);
    logic [31:0] v;
    logic [32:0] r;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    r = {1'b0, v} + (33'd1 << (31 - ANGLE_BITS));
    return ZW'(r >> (32 - ANGLE_BITS));
  endfunction

endpackage

// ===== src/bmo_mul.sv =====
// ---------------------------------------------------------------------------
// bmo_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module bmo_mul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bmo_pkg::MA_W-1:0] a,
  input  logic [bmo_pkg::MB_W-1:0] b,
  output logic                     done,
  output logic [bmo_pkg::MP_W-1:0] prod
);

  localparam int MC_W = $clog2(bmo_pkg::MB_W + 1);

  logic [bmo_pkg::MP_W-1:0] p_r, p_nxt;
  logic [bmo_pkg::MA_W-1:0] a_r, a_nxt;
  logic [MC_W-1:0]          cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [bmo_pkg::MA_W:0]   sum;

  always_comb begin
    sum = {1'b0, p_r[bmo_pkg::MP_W-1:bmo_pkg::MB_W]}
        + (p_r[0] ? {1'b0, a_r} : '0);
    p_nxt    = p_r;
    a_nxt    = a_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      p_nxt    = {bmo_pkg::MA_W'(0), b};
      a_nxt    = a;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt   = {sum, p_r[bmo_pkg::MB_W-1:1]};
      cnt_nxt = cnt_r + MC_W'(1);
      if (cnt_r == MC_W'(bmo_pkg::MB_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    a_r <= a_nxt;
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

// ===== src/bmo_div.sv =====
// ---------------------------------------------------------------------------
// bmo_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bmo_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bmo_pkg::DN_W-1:0] dividend,
  input  logic [bmo_pkg::DD_W-1:0] divisor,
  output logic                     done,
  output logic [bmo_pkg::DN_W-1:0] quotient
);

  localparam int DC_W = $clog2(bmo_pkg::DN_W + 1);

  logic [bmo_pkg::DD_W-1:0] rem_r, rem_nxt;
  logic [bmo_pkg::DD_W-1:0] dvs_r, dvs_nxt;
  logic [bmo_pkg::DN_W-1:0] quo_r, quo_nxt;
  logic [DC_W-1:0]          cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [bmo_pkg::DD_W:0]   r2;
  logic [bmo_pkg::DD_W+1:0] diff;
  logic                     ge;

  always_comb begin
    r2   = {rem_r, quo_r[bmo_pkg::DN_W-1]};
    diff = {1'b0, r2} - {2'b0, dvs_r};
    ge   = !diff[bmo_pkg::DD_W+1];
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // dividend bits shift out the top while quotient bits shift in below
      rem_nxt = ge ? diff[bmo_pkg::DD_W-1:0] : r2[bmo_pkg::DD_W-1:0];
      quo_nxt = {quo_r[bmo_pkg::DN_W-2:0], ge};
      cnt_nxt = cnt_r + DC_W'(1);
      if (cnt_r == DC_W'(bmo_pkg::DN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/bmo_cordic.sv =====
// ---------------------------------------------------------------------------
// bmo_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, Q30 cosine and sine.
// ---------------------------------------------------------------------------
module bmo_cordic (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [bmo_pkg::ANGLE_BITS-1:0]   ang,
  output logic                             done,
  output logic signed [bmo_pkg::CW-1:0]    cos_q,
  output logic signed [bmo_pkg::CW-1:0]    sin_q
);

  localparam int AB = bmo_pkg::ANGLE_BITS;
  localparam int ZW = bmo_pkg::ZW;
  localparam int CW = bmo_pkg::CW;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (AB - 2);
  localparam logic signed [ZW-1:0] HALF    = ZW'(1) << (AB - 1);

  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [CW-1:0] c_r, c_nxt, s_r, s_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 flip_r, flip_nxt;
  logic [bmo_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic signed [ZW-1:0] a_ext, a_red, t;
  logic                 fl;
  logic signed [CW-1:0] xs, ys, xn, yn;

  always_comb begin
    a_ext = ZW'($signed(ang));
    a_red = a_ext;
    fl    = 1'b0;
    // fold into the right half plane, negate the vector at the end
    if (a_ext > QUARTER) begin
      a_red = a_ext - HALF;
      fl    = 1'b1;
    end else if (a_ext < -QUARTER) begin
      a_red = a_ext + HALF;
      fl    = 1'b1;
    end

    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    t  = $signed(bmo_pkg::atan_step(cnt_r));
    if (!z_r[ZW-1]) begin
      xn    = x_r - ys;
      yn    = y_r + xs;
      z_nxt = z_r - t;
    end else begin
      xn    = x_r + ys;
      yn    = y_r - xs;
      z_nxt = z_r + t;
    end

    x_nxt    = x_r;
    y_nxt    = y_r;
    c_nxt    = c_r;
    s_nxt    = s_r;
    flip_nxt = flip_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = CW'(bmo_pkg::GAIN_Q30);
      y_nxt    = '0;
      z_nxt    = a_red;
      flip_nxt = fl;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt   = xn;
      y_nxt   = yn;
      cnt_nxt = cnt_r + bmo_pkg::CNT_W'(1);
      if (cnt_r == bmo_pkg::CNT_W'(bmo_pkg::CSTEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        c_nxt    = flip_r ? -xn : xn;
        s_nxt    = flip_r ? -yn : yn;
      end
    end else begin
      z_nxt = z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    c_r    <= c_nxt;
    s_r    <= s_nxt;
    flip_r <= flip_nxt;
  end

  assign done  = done_r;
  assign cos_q = c_r;
  assign sin_q = s_r;

endmodule

// ===== src/bicycle_model_odometry.sv =====
// ---------------------------------------------------------------------------
// bicycle_model_odometry
// Fixed-point bicycle-model dead reckoning on a shared serial multiplier,
// serial divider and iterative CORDIC.
// Each word runs 5 divides, 8 multiplies, 2 rotations and 1 output step in turn;
//   the yaw divide is skipped when the wheel cosine is zero.
// A new word is taken only once the last is through; the next word is taken while a result waits.
// Reset (synchronous, rst_n low): position 0, heading pi/2, registers to defaults.
// ---------------------------------------------------------------------------
module bicycle_model_odometry (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // speed_kmh[15:0], steer_deg[32:16], time_step_us[52:33], zero fill
  input  logic [55:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], yaw_rate[95:80], speed_ms[111:96]
  output logic [111:0] out_tdata
);

  localparam int AB   = bmo_pkg::ANGLE_BITS;
  localparam int CW   = bmo_pkg::CW;
  localparam int DN_W = bmo_pkg::DN_W;
  localparam int DD_W = bmo_pkg::DD_W;
  localparam int MA_W = bmo_pkg::MA_W;
  localparam int MB_W = bmo_pkg::MB_W;
  localparam int MP_W = bmo_pkg::MP_W;
  localparam int HSL  = (AB >= 16) ? AB - 16 : 0;
  localparam int HSR  = (AB >= 16) ? 0 : 16 - AB;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_V    = 5'd1;
  localparam logic [4:0] S_WA   = 5'd2;
  localparam logic [4:0] S_CW   = 5'd3;
  localparam logic [4:0] S_NUM  = 5'd4;
  localparam logic [4:0] S_DEN  = 5'd5;
  localparam logic [4:0] S_YAW  = 5'd6;
  localparam logic [4:0] S_CH   = 5'd7;
  localparam logic [4:0] S_TX   = 5'd8;
  localparam logic [4:0] S_PX   = 5'd9;
  localparam logic [4:0] S_DX   = 5'd10;
  localparam logic [4:0] S_TY   = 5'd11;
  localparam logic [4:0] S_PY   = 5'd12;
  localparam logic [4:0] S_DY   = 5'd13;
  localparam logic [4:0] S_H1   = 5'd14;
  localparam logic [4:0] S_H2   = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  function automatic logic [31:0] mag32(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] n;
    n = v[CW-1] ? -v : v;
    return n[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // control and architectural state
  logic [4:0]         state_r, state_nxt;
  logic               go_r, go_nxt;
  logic [15:0]        wb_r, wb_nxt, ratio_r, ratio_nxt, db_r, db_nxt;
  logic signed [31:0] x_acc_r, x_acc_nxt, y_acc_r, y_acc_nxt;
  logic [15:0]        head_r, head_nxt;
  logic               out_valid_r, out_valid_nxt;

  // per-word working registers
  logic signed [15:0]   spd_r, spd_nxt;
  logic signed [16:0]   st_r, st_nxt;
  logic [19:0]          dt_r, dt_nxt;
  logic [13:0]          vmag_r, vmag_nxt;
  logic                 vneg_r, vneg_nxt;
  logic [AB-1:0]        wa_r, wa_nxt;
  logic signed [CW-1:0] wc_r, wc_nxt, ws_r, ws_nxt, hc_r, hc_nxt, hs_r, hs_nxt;
  logic [DN_W-1:0]      num_r, num_nxt;
  logic [DD_W-1:0]      den_r, den_nxt;
  logic signed [15:0]   yaw_r, yaw_nxt;
  logic [22:0]          tmag_r, tmag_nxt;
  logic                 tneg_r, tneg_nxt;
  logic [MP_W-1:0]      p_r, p_nxt;
  logic [111:0]         odata_r, odata_nxt;

  // shared units
  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic                 mul_done;
  logic [MP_W-1:0]      mul_p;
  logic [DN_W-1:0]      div_n, div_q;
  logic [DD_W-1:0]      div_d;
  logic                 div_done;
  logic [AB-1:0]        cor_ang;
  logic                 cor_done;
  logic signed [CW-1:0] cor_c, cor_s;

  // helpers
  logic signed [18:0] s5;
  logic [18:0]        m5w;
  logic [16:0]        stabs, stz;
  logic [15:0]        ratio_e, wb_e;
  logic [21:0]        d45;
  logic [27:0]        v16k;
  logic [AB+15:0]     hwide;
  logic [AB-1:0]      hang;
  logic [16:0]        yabs;
  logic [AB-1:0]      qa;
  logic               yneg;
  logic [MP_W-1:0]    rnd;
  logic [23:0]        dmag;
  logic signed [33:0] dsum;
  logic [15:0]        dh;
  logic signed [15:0] vout;

  bmo_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(go_r), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  bmo_div u_div (
    .clk(clk), .rst_n(rst_n), .start(go_r), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quotient(div_q)
  );

  bmo_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(go_r), .ang(cor_ang),
    .done(cor_done), .cos_q(cor_c), .sin_q(cor_s)
  );

  always_comb begin
    s5      = ({{3{spd_r[15]}}, spd_r} <<< 2) + {{3{spd_r[15]}}, spd_r};
    m5w     = s5[18] ? 19'(-s5) : 19'(s5);
    stabs   = st_r[16] ? 17'(-st_r) : 17'(st_r);
    stz     = (stabs < {1'b0, db_r}) ? 17'd0 : stabs;
    ratio_e = (ratio_r == 16'd0) ? 16'd1 : ratio_r;
    wb_e    = (wb_r == 16'd0) ? 16'd1 : wb_r;
    d45     = 22'(ratio_e) * 22'd45;
    v16k    = 28'(vmag_r) * 28'd16000;
    hwide   = {AB'(0), head_r};
    hang    = (AB >= 16) ? AB'(hwide << HSL) : AB'(hwide >> HSR);
    yabs    = yaw_r[15] ? 17'(-{yaw_r[15], yaw_r}) : {1'b0, yaw_r};

    case (state_r)
      S_NUM:   begin mul_a = MA_W'(v16k);        mul_b = mag32(ws_r);      end
      S_DEN:   begin mul_a = MA_W'(mag32(wc_r)); mul_b = MB_W'(wb_e);      end
      S_TX:    begin mul_a = MA_W'(vmag_r);      mul_b = mag32(hc_r);      end
      S_TY:    begin mul_a = MA_W'(vmag_r);      mul_b = mag32(hs_r);      end
      S_PX:    begin mul_a = MA_W'(tmag_r);      mul_b = MB_W'(dt_r);      end
      S_PY:    begin mul_a = MA_W'(tmag_r);      mul_b = MB_W'(dt_r);      end
      S_H1:    begin mul_a = MA_W'(yabs);        mul_b = MB_W'(dt_r);      end
      S_H2:    begin mul_a = p_r[MA_W-1:0];      mul_b = MB_W'(bmo_pkg::HEAD_K); end
      default: begin mul_a = '0;                 mul_b = '0;               end
    endcase

    // dividends carry half the divisor so the quotient rounds to nearest
    case (state_r)
      S_V: begin
        div_n = DN_W'(m5w[17:0]) + DN_W'(9);
        div_d = DD_W'(18);
      end
      S_WA: begin
        div_n = (DN_W'(stz) << (AB - 1)) + DN_W'(d45 >> 1);
        div_d = DD_W'(d45);
      end
      S_YAW: begin
        div_n = num_r + DN_W'(den_r >> 1);
        div_d = den_r;
      end
      S_DX, S_DY: begin
        div_n = p_r[DN_W-1:0] + DN_W'(500000);
        div_d = DD_W'(1000000);
      end
      default: begin
        div_n = '0;
        div_d = DD_W'(1);
      end
    endcase

    cor_ang = (state_r == S_CW) ? wa_r : hang;

    qa   = div_q[AB-1:0];
    yneg = vneg_r ^ ws_r[CW-1] ^ wc_r[CW-1];
    dmag = div_q[23:0];
    dsum = tneg_r ? 34'(x_acc_r) - 34'(dmag) : 34'(x_acc_r) + 34'(dmag);
    if (state_r == S_DY) begin
      dsum = tneg_r ? 34'(y_acc_r) - 34'(dmag) : 34'(y_acc_r) + 34'(dmag);
    end
    rnd  = (state_r == S_H2) ? (mul_p + (MP_W'(1) << 39)) >> 40
                             : (mul_p + (MP_W'(1) << 21)) >> 22;
    dh   = yaw_r[15] ? 16'(-rnd[15:0]) : rnd[15:0];
    vout = vneg_r ? 16'(-{2'b0, vmag_r}) : {2'b0, vmag_r};

    state_nxt     = state_r;
    go_nxt        = 1'b0;
    wb_nxt        = wb_r;
    ratio_nxt     = ratio_r;
    db_nxt        = db_r;
    x_acc_nxt     = x_acc_r;
    y_acc_nxt     = y_acc_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r;
    spd_nxt  = spd_r;
    st_nxt   = st_r;
    dt_nxt   = dt_r;
    vmag_nxt = vmag_r;
    vneg_nxt = vneg_r;
    wa_nxt   = wa_r;
    wc_nxt   = wc_r;
    ws_nxt   = ws_r;
    hc_nxt   = hc_r;
    hs_nxt   = hs_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    yaw_nxt  = yaw_r;
    tmag_nxt = tmag_r;
    tneg_nxt = tneg_r;
    p_nxt    = p_r;
    odata_nxt = odata_r;

    if (cfg_we) begin
      case (cfg_addr)
        bmo_pkg::REG_WHEELBASE: wb_nxt    = cfg_wdata;
        bmo_pkg::REG_RATIO:     ratio_nxt = cfg_wdata;
        bmo_pkg::REG_DEADBAND:  db_nxt    = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          spd_nxt   = in_tdata[15:0];
          st_nxt    = in_tdata[32:16];
          dt_nxt    = in_tdata[52:33];
          state_nxt = S_V;
          go_nxt    = 1'b1;
        end
      end
      S_V: begin
        if (div_done) begin
          vmag_nxt  = div_q[13:0];
          vneg_nxt  = spd_r[15];
          state_nxt = S_WA;
          go_nxt    = 1'b1;
        end
      end
      S_WA: begin
        if (div_done) begin
          wa_nxt    = st_r[16] ? AB'(-qa) : qa;
          state_nxt = S_CW;
          go_nxt    = 1'b1;
        end
      end
      S_CW: begin
        if (cor_done) begin
          wc_nxt    = cor_c;
          ws_nxt    = cor_s;
          state_nxt = S_NUM;
          go_nxt    = 1'b1;
        end
      end
      S_NUM: begin
        if (mul_done) begin
          num_nxt   = mul_p[DN_W-1:0];
          state_nxt = S_DEN;
          go_nxt    = 1'b1;
        end
      end
      S_DEN: begin
        if (mul_done) begin
          den_nxt = mul_p[DD_W-1:0];
          go_nxt  = 1'b1;
          if (mul_p == '0) begin
            // wheel at right angle: saturate toward the numerator's sign
            if (num_r == '0) yaw_nxt = 16'sd0;
            else if (vneg_r ^ ws_r[CW-1]) yaw_nxt = -16'sd32768;
            else yaw_nxt = 16'sd32767;
            state_nxt = S_CH;
          end else begin
            state_nxt = S_YAW;
          end
        end
      end
      S_YAW: begin
        if (div_done) begin
          if (!yneg) begin
            yaw_nxt = (div_q > DN_W'(32767)) ? 16'sd32767 : div_q[15:0];
          end else begin
            yaw_nxt = (div_q > DN_W'(32768)) ? -16'sd32768 : 16'(-div_q[15:0]);
          end
          state_nxt = S_CH;
          go_nxt    = 1'b1;
        end
      end
      S_CH: begin
        if (cor_done) begin
          hc_nxt    = cor_c;
          hs_nxt    = cor_s;
          state_nxt = S_TX;
          go_nxt    = 1'b1;
        end
      end
      S_TX, S_TY: begin
        if (mul_done) begin
          tmag_nxt  = rnd[22:0];
          tneg_nxt  = vneg_r ^ ((state_r == S_TX) ? hc_r[CW-1] : hs_r[CW-1]);
          state_nxt = (state_r == S_TX) ? S_PX : S_PY;
          go_nxt    = 1'b1;
        end
      end
      S_PX, S_PY: begin
        if (mul_done) begin
          p_nxt     = mul_p;
          state_nxt = (state_r == S_PX) ? S_DX : S_DY;
          go_nxt    = 1'b1;
        end
      end
      S_DX: begin
        if (div_done) begin
          x_acc_nxt = sat32(dsum);
          state_nxt = S_TY;
          go_nxt    = 1'b1;
        end
      end
      S_DY: begin
        if (div_done) begin
          y_acc_nxt = sat32(dsum);
          state_nxt = S_H1;
          go_nxt    = 1'b1;
        end
      end
      S_H1: begin
        if (mul_done) begin
          p_nxt     = mul_p;
          state_nxt = S_H2;
          go_nxt    = 1'b1;
        end
      end
      S_H2: begin
        if (mul_done) begin
          head_nxt  = head_r + dh;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold the finished word until the output register frees up
        if (!out_valid_r || out_tready) begin
          odata_nxt     = {vout, yaw_r, head_r, y_acc_r, x_acc_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      wb_r        <= 16'd1000;
      ratio_r     <= 16'd8192;
      db_r        <= 16'd576;
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      head_r      <= 16'd16384;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      wb_r        <= wb_nxt;
      ratio_r     <= ratio_nxt;
      db_r        <= db_nxt;
      x_acc_r     <= x_acc_nxt;
      y_acc_r     <= y_acc_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spd_r   <= spd_nxt;
    st_r    <= st_nxt;
    dt_r    <= dt_nxt;
    vmag_r  <= vmag_nxt;
    vneg_r  <= vneg_nxt;
    wa_r    <= wa_nxt;
    wc_r    <= wc_nxt;
    ws_r    <= ws_nxt;
    hc_r    <= hc_nxt;
    hs_r    <= hs_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    yaw_r   <= yaw_nxt;
    tmag_r  <= tmag_nxt;
    tneg_r  <= tneg_nxt;
    p_r     <= p_nxt;
    odata_r <= odata_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = odata_r;

endmodule
